// File: rtl/core/tbht_pkg.sv
// ----------------------------------------------------------------------------
// tbht_pkg
// Shared types and constants for the topmost box hit test block.
// ----------------------------------------------------------------------------
package tbht_pkg;

    // default number of table slots
    localparam int TABLE_DEPTH_DEF = 64;

    // field widths fixed by the interface
    localparam int COORD_W  = 24;
    localparam int SIZE_W   = 16;
    localparam int ID_W     = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register addresses
    localparam logic [APB_AW-1:0] ADDR_ACTIVE_COUNT = 3'd0;

    // one table entry
    typedef struct packed {
        logic signed [COORD_W-1:0] ctr_x;
        logic signed [COORD_W-1:0] ctr_z;
        logic [SIZE_W-1:0]         size_x;
        logic [SIZE_W-1:0]         size_z;
        logic [ID_W-1:0]           unit_id;
        logic                      hidden;
    } t_entry;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/topmost_box_hit_test_top.sv
// ----------------------------------------------------------------------------
// topmost_box_hit_test_top
// Box table with a topmost-hit point query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command per beat. A write
//   beat (command 0) stores the entry fields at entry_index and gives no
//   result. A query beat (command 1) scans entries
//   min(active_count, TABLE_DEPTH)-1 down to 0, one memory read per cycle,
//   and stops at the first visible box that holds the point.
//   A query occupies the block until its scan ends: the single memory read
//   port and the one shared box test handle one entry at a time. o_stall is
//   high meanwhile. The result beat (o_valid / i_stall) gives hit and
//   picked_id, zero on a miss. It sits in an output register: a new command
//   is accepted while it waits. If a second result is ready while the
//   receiver stalls, the block holds it and stays busy until the register
//   frees. active_count is written over the APB port at address 0; the user
//   must write it only while idle, which the block does not enforce. Reset
//   clears active_count and all control state; the table contents are
//   undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module topmost_box_hit_test_top #(
    parameter int TABLE_DEPTH = tbht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tbht_pkg::APB_AW-1:0]         paddr,
    input  logic [tbht_pkg::APB_DW-1:0]         pwdata,
    output logic [tbht_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [tbht_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_ctr_x,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_ctr_z,
    input  logic [tbht_pkg::SIZE_W-1:0]         i_size_x,
    input  logic [tbht_pkg::SIZE_W-1:0]         i_size_z,
    input  logic [tbht_pkg::ID_W-1:0]           i_unit_id,
    input  logic                                i_hidden,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_query_z,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [tbht_pkg::ID_W-1:0]           o_picked_id
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [tbht_pkg::COUNT_W-1:0]        r_active_count;
    logic                                w_cfg_wr;
    tbht_pkg::t_entry                    w_wr_data;
    tbht_pkg::t_entry                    w_rd_data;
    logic                                w_wr_en;
    logic [AW-1:0]                       w_wr_addr;
    logic                                w_rd_en;
    logic [AW-1:0]                       w_rd_addr;
    logic signed [tbht_pkg::COORD_W-1:0] w_qx;
    logic signed [tbht_pkg::COORD_W-1:0] w_qz;
    logic                                w_rd_hit;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr == tbht_pkg::ADDR_ACTIVE_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
        end else if (w_cfg_wr) begin
            r_active_count <= pwdata[tbht_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == tbht_pkg::ADDR_ACTIVE_COUNT) begin
            prdata = tbht_pkg::APB_DW'(r_active_count);
        end else begin
            prdata = '0;
        end
    end

    // entry written by a write beat
    assign w_wr_data = '{ctr_x:   i_ctr_x,
                         ctr_z:   i_ctr_z,
                         size_x:  i_size_x,
                         size_z:  i_size_z,
                         unit_id: i_unit_id,
                         hidden:  i_hidden};

    tbht_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_entry_index  (i_entry_index),
        .i_query_x      (i_query_x),
        .i_query_z      (i_query_z),
        .i_active_count (r_active_count),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .o_qx           (w_qx),
        .o_qz           (w_qz),
        .i_rd_hit       (w_rd_hit),
        .i_rd_id        (w_rd_data.unit_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_picked_id    (o_picked_id)
    );

    tbht_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tbht_hit_unit u_hit (
        .i_qx    (w_qx),
        .i_qz    (w_qz),
        .i_entry (w_rd_data),
        .o_hit   (w_rd_hit)
    );

endmodule

// File: rtl/core/tbht_table.sv
// ----------------------------------------------------------------------------
// tbht_table
// Box table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tbht_table #(
    parameter int DEPTH = tbht_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  tbht_pkg::t_entry     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output tbht_pkg::t_entry     o_rd_data
);

    tbht_pkg::t_entry r_mem [DEPTH];
    tbht_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered: data is valid in the cycle after the request
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/tbht_hit_unit.sv
// ----------------------------------------------------------------------------
// tbht_hit_unit
// Containment test of the query point against one table entry per cycle.
// ----------------------------------------------------------------------------
module tbht_hit_unit (
    input  logic signed [tbht_pkg::COORD_W-1:0] i_qx,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_qz,
    input  tbht_pkg::t_entry                    i_entry,
    output logic                                o_hit
);

    localparam int DW = tbht_pkg::COORD_W + 1;
    localparam int TW = tbht_pkg::COORD_W + 2;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dz;
    logic signed [TW-1:0] w_2dx;
    logic signed [TW-1:0] w_2dz;
    logic signed [TW-1:0] w_sx;
    logic signed [TW-1:0] w_sz;
    logic                 w_in_x;
    logic                 w_in_z;

    // offsets, exact in one extra bit
    assign w_dx = DW'(i_qx) - DW'(i_entry.ctr_x);
    assign w_dz = DW'(i_qz) - DW'(i_entry.ctr_z);

    assign w_2dx = {w_dx, 1'b0};
    assign w_2dz = {w_dz, 1'b0};
    assign w_sx  = signed'(TW'(i_entry.size_x));
    assign w_sz  = signed'(TW'(i_entry.size_z));

    // 2|d| <= size: positive side compares, negative side checks 2d + size >= 0
    always_comb begin
        if (w_dx[DW-1]) begin
            w_in_x = !(w_2dx + w_sx < 0);
        end else begin
            w_in_x = (w_2dx <= w_sx);
        end
        if (w_dz[DW-1]) begin
            w_in_z = !(w_2dz + w_sz < 0);
        end else begin
            w_in_z = (w_2dz <= w_sz);
        end
    end

    assign o_hit = !i_entry.hidden && w_in_x && w_in_z;

endmodule

// File: rtl/core/tbht_seq.sv
// ----------------------------------------------------------------------------
// tbht_seq
// Command sequencer: stores writes, scans the table downward for a query and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tbht_seq #(
    parameter int TABLE_DEPTH = tbht_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [tbht_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [tbht_pkg::COORD_W-1:0] i_query_z,
    // configuration
    input  logic [tbht_pkg::COUNT_W-1:0]        i_active_count,
    // table access
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    // hit unit
    output logic signed [tbht_pkg::COORD_W-1:0] o_qx,
    output logic signed [tbht_pkg::COORD_W-1:0] o_qz,
    input  logic                                i_rd_hit,
    input  logic [tbht_pkg::ID_W-1:0]           i_rd_id,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [tbht_pkg::ID_W-1:0]           o_picked_id
);

    tbht_pkg::t_state                    r_state, n_state;
    logic [CNT_W-1:0]                    r_cnt, n_cnt;
    logic                                r_pend, n_pend;
    logic signed [tbht_pkg::COORD_W-1:0] r_qx, n_qx;
    logic signed [tbht_pkg::COORD_W-1:0] r_qz, n_qz;
    logic                                r_res_hit, n_res_hit;
    logic [tbht_pkg::ID_W-1:0]           r_res_id, n_res_id;
    logic                                r_out_vld;
    logic                                r_out_hit;
    logic [tbht_pkg::ID_W-1:0]           r_out_id;

    logic                                w_acc;
    logic                                w_out_free;
    logic [CNT_W-1:0]                    w_n;
    logic [CNT_W-1:0]                    w_cnt_m1;
    logic                                w_rd_en;
    logic                                w_finish;
    logic                                w_fin_hit;
    logic [tbht_pkg::ID_W-1:0]           w_fin_id;
    logic                                w_load;

    assign o_stall    = (r_state != tbht_pkg::ST_IDLE);
    assign w_acc      = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;

    // entries to scan, clipped to the table depth
    always_comb begin
        if (32'(i_active_count) > TABLE_DEPTH) begin
            w_n = CNT_W'(TABLE_DEPTH);
        end else begin
            w_n = CNT_W'(i_active_count);
        end
    end

    // table write on an accepted write beat inside the table
    assign o_wr_en   = w_acc && (i_command == tbht_pkg::CMD_WRITE)
                       && (32'(i_entry_index) < TABLE_DEPTH);
    assign o_wr_addr = AW'(32'(i_entry_index));

    // read address walks from the top slot down
    assign w_cnt_m1  = r_cnt - CNT_W'(1);
    assign o_rd_addr = w_cnt_m1[AW-1:0];
    assign o_rd_en   = w_rd_en;

    assign o_qx = r_qx;
    assign o_qz = r_qz;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbht_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    // query point and held result
    always_ff @(posedge i_clk) begin
        r_qx      <= n_qx;
        r_qz      <= n_qz;
        r_res_hit <= n_res_hit;
        r_res_id  <= n_res_id;
    end

    // next state and scan control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pend    = 1'b0;
        n_qx      = r_qx;
        n_qz      = r_qz;
        n_res_hit = r_res_hit;
        n_res_id  = r_res_id;
        w_rd_en   = 1'b0;
        w_finish  = 1'b0;
        w_fin_hit = 1'b0;
        w_fin_id  = '0;
        w_load    = 1'b0;
        unique case (r_state)
            tbht_pkg::ST_IDLE: begin
                if (w_acc && (i_command == tbht_pkg::CMD_QUERY)) begin
                    n_qx    = i_query_x;
                    n_qz    = i_query_z;
                    n_cnt   = w_n;
                    n_state = tbht_pkg::ST_SCAN;
                end
            end
            tbht_pkg::ST_SCAN: begin
                if (r_pend && i_rd_hit) begin
                    w_finish  = 1'b1;
                    w_fin_hit = 1'b1;
                    w_fin_id  = i_rd_id;
                end else if (r_cnt == '0) begin
                    w_finish = 1'b1;
                end else begin
                    w_rd_en = 1'b1;
                    n_cnt   = w_cnt_m1;
                    n_pend  = 1'b1;
                end
                if (w_finish) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = tbht_pkg::ST_IDLE;
                    end else begin
                        n_res_hit = w_fin_hit;
                        n_res_id  = w_fin_id;
                        n_state   = tbht_pkg::ST_DONE;
                    end
                end
            end
            tbht_pkg::ST_DONE: begin
                w_fin_hit = r_res_hit;
                w_fin_id  = r_res_id;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = tbht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbht_pkg::ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_hit <= w_fin_hit;
            r_out_id  <= w_fin_id;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hit       = r_out_hit;
    assign o_picked_id = r_out_id;

`ifndef SYNTHESIS
    // a query beat always starts a scan
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_command == tbht_pkg::CMD_QUERY)) |=> o_stall)
        else $error("query beat did not start a scan");

    // a write beat leaves the block ready
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_command == tbht_pkg::CMD_WRITE)) |=> !o_stall)
        else $error("write beat left the block busy");

    // a miss carries a zero id
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_hit) |-> (r_out_id == '0))
        else $error("miss result with nonzero id");

    // read data is only pending during a scan
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == tbht_pkg::ST_SCAN))
        else $error("read pending outside a scan");

    // scan counter never exceeds the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= TABLE_DEPTH)
        else $error("scan counter beyond table depth");
`endif

endmodule
